### rtl/scl_pkg.sv
// Package for the sorted card list: sizes, operation and status codes,
// the stored card type and the records passed between sequencer and store.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package scl_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int MODE_W   = 3;
  localparam int COLOR_W  = 2;
  localparam int NUMBER_W = 4;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD     = 3'd0,
    MODE_FIND    = 3'd1,
    MODE_DEL_VAL = 3'd2,
    MODE_DEL_POS = 3'd3,
    MODE_GET     = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  typedef struct packed {
    logic [COLOR_W-1:0]  color;
    logic [NUMBER_W-1:0] number;
  } card_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    card_t            wr_data;
    logic [IDX_W-1:0] rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] count;
  } seq_stat_t;

endpackage

`default_nettype wire

### rtl/scl_if.sv
// Channel interfaces of the sorted card list: operation beats in, result beats out.
// Depends on scl_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface scl_op_if;
  import scl_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [COLOR_W-1:0]  card_color;
  logic [NUMBER_W-1:0] card_number;
  logic [POS_W-1:0]    position;

  modport source (output valid, mode, card_color, card_number, position, input ready);
  modport sink   (input valid, mode, card_color, card_number, position, output ready);
endinterface

interface scl_res_if;
  import scl_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    found_position;
  logic [COLOR_W-1:0]  out_color;
  logic [NUMBER_W-1:0] out_number;
  logic [COUNT_W-1:0]  card_count;

  modport source (output valid, status, found_position, out_color, out_number, card_count,
                  input ready);
  modport sink   (input valid, status, found_position, out_color, out_number, card_count,
                  output ready);
endinterface

`default_nettype wire

### rtl/scl_store.sv
// Card store: one synchronous memory, one write and one registered read per cycle.
// Depends on scl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scl_store (
  input  logic             clk,
  input  scl_pkg::mem_req_t req,
  output scl_pkg::card_t   rd_data
);
  import scl_pkg::*;

  card_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end

endmodule

`default_nettype wire

### rtl/scl_seq.sv
// Operation sequencer: walks the card store for add, find, delete and get,
// keeps the card count and holds the result register.
// Depends on scl_pkg, scl_if.
`timescale 1ns / 1ps
`default_nettype none

module scl_seq (
  input  logic               clk,
  input  logic               rst,
  scl_op_if.sink             op,
  scl_res_if.source          res,
  output scl_pkg::mem_req_t  mem_req,
  input  scl_pkg::card_t     rd_data,
  output scl_pkg::seq_stat_t stat
);
  import scl_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_ADD_RD   = 10'b0000000010,
    S_ADD_CMP  = 10'b0000000100,
    S_ADD_LAST = 10'b0000001000,
    S_FIND_RD  = 10'b0000010000,
    S_FIND_CMP = 10'b0000100000,
    S_SHIFT_RD = 10'b0001000000,
    S_SHIFT_WR = 10'b0010000000,
    S_GET_RD   = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_t;

  state_t              state, state_next;
  logic [IDX_W-1:0]    idx, idx_next;
  logic [CNT_W-1:0]    count, count_next;
  mode_t               w_mode, w_mode_next;
  card_t               w_card, w_card_next;
  status_t             r_status, r_status_next;
  logic [POS_W-1:0]    r_where, r_where_next;
  card_t               r_card, r_card_next;
  logic                get_pend, get_pend_next;

  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [POS_W-1:0]    out_where;
  logic [COLOR_W-1:0]  out_color;
  logic [NUMBER_W-1:0] out_number;
  logic [COUNT_W-1:0]  out_count;

  logic [COUNT_W-1:0]  cnt_ext;
  logic [COUNT_W-1:0]  pos_ext;
  logic [COUNT_W-1:0]  idx_inc;
  logic                out_free;

  assign cnt_ext  = COUNT_W'(count);
  assign pos_ext  = COUNT_W'(op.position);
  assign idx_inc  = COUNT_W'(idx) + COUNT_W'(1);
  assign out_free = !out_valid || res.ready;

  assign op.ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    count_next    = count;
    w_mode_next   = w_mode;
    w_card_next   = w_card;
    r_status_next = r_status;
    r_where_next  = r_where;
    r_card_next   = r_card;
    get_pend_next = 1'b0;
    mem_req       = '0;
    mem_req.rd_addr = idx;

    unique case (state)
      S_IDLE: begin
        if (op.valid) begin
          w_mode_next   = mode_t'(op.mode);
          w_card_next   = '{color: op.card_color, number: op.card_number};
          r_status_next = ST_MISS;
          r_where_next  = '0;
          r_card_next   = '0;
          state_next    = S_DONE;
          unique case (op.mode) inside
            MODE_ADD: begin
              if (cnt_ext == COUNT_W'(CAPACITY)) begin
                r_status_next = ST_FULL;
              end else if (count == '0) begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = '0;
                mem_req.wr_data = '{color: op.card_color, number: op.card_number};
                count_next      = count + CNT_W'(1);
                r_status_next   = ST_OK;
              end else begin
                idx_next   = IDX_W'(count - CNT_W'(1));
                state_next = S_ADD_RD;
              end
            end
            MODE_FIND, MODE_DEL_VAL: begin
              if (count != '0) begin
                idx_next   = '0;
                state_next = S_FIND_RD;
              end
            end
            MODE_DEL_POS: begin
              if (pos_ext < cnt_ext) begin
                r_status_next = ST_OK;
                r_where_next  = op.position;
                idx_next      = IDX_W'(op.position);
                if (pos_ext + COUNT_W'(1) == cnt_ext) begin
                  count_next = count - CNT_W'(1);
                end else begin
                  state_next = S_SHIFT_RD;
                end
              end
            end
            MODE_GET: begin
              if (pos_ext < cnt_ext) begin
                idx_next   = IDX_W'(op.position);
                state_next = S_GET_RD;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_ADD_RD: begin
        state_next = S_ADD_CMP;
      end
      S_ADD_CMP: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = IDX_W'(idx_inc);
        if (rd_data.number > w_card.number) begin
          mem_req.wr_data = rd_data;
          if (idx == '0) begin
            state_next = S_ADD_LAST;
          end else begin
            idx_next   = idx - IDX_W'(1);
            state_next = S_ADD_RD;
          end
        end else begin
          mem_req.wr_data = w_card;
          r_where_next    = POS_W'(idx_inc);
          r_status_next   = ST_OK;
          count_next      = count + CNT_W'(1);
          state_next      = S_DONE;
        end
      end
      S_ADD_LAST: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = '0;
        mem_req.wr_data = w_card;
        r_where_next    = '0;
        r_status_next   = ST_OK;
        count_next      = count + CNT_W'(1);
        state_next      = S_DONE;
      end
      S_FIND_RD: begin
        state_next = S_FIND_CMP;
      end
      S_FIND_CMP: begin
        if (rd_data == w_card) begin
          r_status_next = ST_OK;
          r_where_next  = POS_W'(idx);
          state_next    = S_DONE;
          if (w_mode == MODE_DEL_VAL) begin
            if (idx_inc == cnt_ext) begin
              count_next = count - CNT_W'(1);
            end else begin
              state_next = S_SHIFT_RD;
            end
          end
        end else if (idx_inc == cnt_ext) begin
          state_next = S_DONE;
        end else begin
          idx_next   = IDX_W'(idx_inc);
          state_next = S_FIND_RD;
        end
      end
      S_SHIFT_RD: begin
        mem_req.rd_addr = IDX_W'(idx_inc);
        state_next      = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = idx;
        mem_req.wr_data = rd_data;
        if (idx_inc + COUNT_W'(1) == cnt_ext) begin
          count_next = count - CNT_W'(1);
          state_next = S_DONE;
        end else begin
          idx_next   = IDX_W'(idx_inc);
          state_next = S_SHIFT_RD;
        end
      end
      S_GET_RD: begin
        get_pend_next = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (get_pend) begin
          r_card_next   = rd_data;
          r_status_next = ST_OK;
          r_where_next  = POS_W'(idx);
          get_pend_next = 1'b0;
        end else if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      get_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      get_pend <= get_pend_next;
      if (state == S_DONE && !get_pend && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    w_mode   <= w_mode_next;
    w_card   <= w_card_next;
    r_status <= r_status_next;
    r_where  <= r_where_next;
    r_card   <= r_card_next;
    if (state == S_DONE && !get_pend && out_free) begin
      out_status <= r_status;
      out_where  <= r_where;
      out_color  <= r_card.color;
      out_number <= r_card.number;
      out_count  <= COUNT_W'(count);
    end
  end

  assign res.valid          = out_valid;
  assign res.status         = out_status;
  assign res.found_position = out_where;
  assign res.out_color      = out_color;
  assign res.out_number     = out_number;
  assign res.card_count     = out_count;

  assign stat.busy  = (state != S_IDLE);
  assign stat.count = count;

endmodule

`default_nettype wire

### rtl/sorted_card_list_core.sv
// Sorted card list top level: sequencer plus card store, with port assertions.
// Depends on scl_pkg, scl_if, scl_store, scl_seq.
//
// Keeps up to CAPACITY cards ordered by rank in a single-port-read, single-port-write
// memory and runs one operation at a time. Each operation walks the memory one entry
// per step; add and delete steps read an entry and then write it back one place over,
// while find steps only read and compare. Get reads the entry at the given position;
// find stops at the first match or after the last card; add walks down from the top,
// moving each stored card that ranks above the new one, and writes directly into an
// empty list or reports a full one; delete by position of the last card moves nothing,
// and a delete otherwise moves each later card to close the gap. The result stays in
// an output register, so a new operation is accepted while the previous result waits;
// a later result holds until the previous one is taken.
`timescale 1ns / 1ps
`default_nettype none

module sorted_card_list_core (
  input  logic      clk,
  input  logic      rst,
  scl_op_if.sink    op,
  scl_res_if.source res
);
  import scl_pkg::*;

  mem_req_t  mem_req;
  card_t     rd_data;
  seq_stat_t stat;

  scl_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .op      (op),
    .res     (res),
    .mem_req (mem_req),
    .rd_data (rd_data),
    .stat    (stat)
  );

  scl_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status == ST_FULL |-> res.card_count == COUNT_W'(CAPACITY))
    else $error("full status with list not full");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    op.valid && op.ready |=> stat.busy)
    else $error("accepted beat did not start the sequencer");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stat.count <= CNT_W'(CAPACITY))
    else $error("card count above capacity");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status != ST_OK |->
      res.out_color == '0 && res.out_number == '0 && res.found_position == '0)
    else $error("failed result carries nonzero fields");

endmodule

`default_nettype wire
